[hdl/assert_macros.svh]
// Assertion macros shared by the RTL of the multiset bag engine.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, expr)
`define ASSERT_IMPLIES(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[hdl/mbe_pkg.sv]
// Package of the multiset bag engine: capacities, derived widths, codes and
// the payload structs of both channels. It depends on nothing else.
package mbe_pkg;

  localparam int DISTINCT_MAX = 16;
  localparam int BAG_MAX      = 64;
  localparam int VALUE_BITS   = 32;

  localparam int ELEM_W    = 32;
  localparam int CNT_OUT_W = 7;

  // Only the low bits that take part in comparisons are stored.
  localparam int CMP_W  = (VALUE_BITS < ELEM_W) ? VALUE_BITS : ELEM_W;
  localparam int DIDX_W = $clog2(DISTINCT_MAX);
  localparam int DCNT_W = $clog2(DISTINCT_MAX + 1);
  localparam int SIDX_W = $clog2(BAG_MAX);
  localparam int SCNT_W = $clog2(BAG_MAX + 1);
  localparam int PTR_W  = (DCNT_W > SCNT_W) ? DCNT_W : SCNT_W;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;
  localparam logic [1:0] OP_COUNT  = 2'd3;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  typedef struct packed {
    logic [1:0]               op;
    logic signed [ELEM_W-1:0] elem_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]           status;
    logic                 present;
    logic [CNT_OUT_W-1:0] occurrences;
    logic [CNT_OUT_W-1:0] total_count;
    logic                 is_empty;
  } out_item_t;

  // Fits a slot count into the result field, truncating or zero extending.
  function automatic logic [CNT_OUT_W-1:0] cnt_out(input logic [SCNT_W-1:0] x);
    logic [CNT_OUT_W+SCNT_W-1:0] w;
    w = '0;
    w[SCNT_W-1:0] = x;
    return w[CNT_OUT_W-1:0];
  endfunction

endpackage

[hdl/mbe_ram.sv]
// Generic single write port, single read port RAM with registered read data.
// Used for both tables of the multiset bag engine; no package dependency.
module mbe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/multiset_bag_engine_unit.sv]
// Multiset bag engine: one operation (add, remove, search, count) per item on
// a bag of up to BAG_MAX occurrences of up to DISTINCT_MAX distinct values.
// Uses mbe_pkg, mbe_ram and assert_macros.svh.
//
// The block accepts no new item until its result is loaded into the output
// register; a result waiting there does not block the next transfer in. Both
// tables live in RAMs with registered reads and every pass walks one entry
// per cycle over the fill levels D (distinct values) and S (slots): search,
// count and add do a value lookup and a count pass, and a remove of a present
// value does the lookup, a first-slot search, a recount, and a renumbering
// pass when the last occurrence of a value goes. No clearing pass is needed
// after reset: entries are only read once they have been written.
`include "assert_macros.svh"

module multiset_bag_engine_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mbe_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output mbe_pkg::out_item_t out_data
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FIND  = 4'd1;
  localparam logic [3:0] S_CNT   = 4'd2;
  localparam logic [3:0] S_POS   = 4'd3;
  localparam logic [3:0] S_LAST  = 4'd4;
  localparam logic [3:0] S_MOVE  = 4'd5;
  localparam logic [3:0] S_DLAST = 4'd6;
  localparam logic [3:0] S_DMOVE = 4'd7;
  localparam logic [3:0] S_RENUM = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0]                   state_r, state_nxt;
  logic [1:0]                   op_r, op_nxt;
  logic [mbe_pkg::CMP_W-1:0]    val_r, val_nxt;
  logic [mbe_pkg::DCNT_W-1:0]   dcnt_r, dcnt_nxt;
  logic [mbe_pkg::SCNT_W-1:0]   scnt_r, scnt_nxt;
  logic [mbe_pkg::PTR_W-1:0]    ptr_r, ptr_nxt;
  logic                         pend_r, pend_nxt;
  logic [mbe_pkg::PTR_W-1:0]    pidx_r, pidx_nxt;
  logic                         found_r, found_nxt;
  logic [mbe_pkg::DIDX_W-1:0]   idx_r, idx_nxt;
  logic [mbe_pkg::SCNT_W-1:0]   cnt_r, cnt_nxt;
  logic [mbe_pkg::SIDX_W-1:0]   pos_r, pos_nxt;
  logic [1:0]                   status_r, status_nxt;
  logic                         out_valid_r, out_valid_nxt;
  mbe_pkg::out_item_t           out_r, out_nxt;

  logic                         d_we;
  logic [mbe_pkg::DIDX_W-1:0]   d_waddr, d_raddr;
  logic [mbe_pkg::CMP_W-1:0]    d_wdata, d_rdata;
  logic                         s_we;
  logic [mbe_pkg::SIDX_W-1:0]   s_waddr, s_raddr;
  logic [mbe_pkg::DIDX_W-1:0]   s_wdata, s_rdata;

  logic                         scanning, issue, scan_end;
  logic [mbe_pkg::PTR_W-1:0]    scan_limit;
  logic [mbe_pkg::DCNT_W-1:0]   dcnt_m1;
  logic [mbe_pkg::SCNT_W-1:0]   scnt_m1;
  logic [mbe_pkg::DIDX_W-1:0]   d_last;
  logic [mbe_pkg::SIDX_W-1:0]   s_last;
  logic                         d_hit, s_hit, s_hit_last;
  logic                         d_full, s_full;
  logic                         f_hit;
  logic [mbe_pkg::DIDX_W-1:0]   f_idx;

  mbe_ram #(.WIDTH(mbe_pkg::CMP_W), .DEPTH(mbe_pkg::DISTINCT_MAX)) u_distinct (
    .clk   (clk),
    .we    (d_we),
    .waddr (d_waddr),
    .wdata (d_wdata),
    .raddr (d_raddr),
    .rdata (d_rdata)
  );

  mbe_ram #(.WIDTH(mbe_pkg::DIDX_W), .DEPTH(mbe_pkg::BAG_MAX)) u_slots (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign dcnt_m1 = dcnt_r - 1'b1;
  assign scnt_m1 = scnt_r - 1'b1;
  assign d_last  = dcnt_m1[mbe_pkg::DIDX_W-1:0];
  assign s_last  = scnt_m1[mbe_pkg::SIDX_W-1:0];
  assign d_full  = (dcnt_r >= mbe_pkg::DISTINCT_MAX);
  assign s_full  = (scnt_r >= mbe_pkg::BAG_MAX);

  // Read data always belongs to the read issued in the previous cycle (pidx_r).
  assign d_hit      = pend_r && (d_rdata == val_r);
  assign s_hit      = pend_r && (s_rdata == idx_r);
  assign s_hit_last = pend_r && (s_rdata == d_last);
  assign f_hit      = d_hit;
  assign f_idx      = d_hit ? pidx_r[mbe_pkg::DIDX_W-1:0] : dcnt_r[mbe_pkg::DIDX_W-1:0];

  always_comb begin
    scan_limit = '0;
    if (state_r == S_FIND) begin
      scan_limit[mbe_pkg::DCNT_W-1:0] = dcnt_r;
    end else begin
      scan_limit[mbe_pkg::SCNT_W-1:0] = scnt_r;
    end
  end

  assign scanning = (state_r inside {S_FIND, S_CNT, S_POS, S_RENUM});
  assign issue    = scanning && (ptr_r < scan_limit);
  assign scan_end = !issue && !pend_r;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    val_nxt       = val_r;
    dcnt_nxt      = dcnt_r;
    scnt_nxt      = scnt_r;
    ptr_nxt       = issue ? ptr_r + 1'b1 : ptr_r;
    pend_nxt      = issue;
    pidx_nxt      = ptr_r;
    found_nxt     = found_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    pos_nxt       = pos_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    d_we          = 1'b0;
    d_waddr       = idx_r;
    d_wdata       = val_r;
    d_raddr       = ptr_r[mbe_pkg::DIDX_W-1:0];
    s_we          = 1'b0;
    s_waddr       = pos_r;
    s_wdata       = idx_r;
    s_raddr       = ptr_r[mbe_pkg::SIDX_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_data.op;
          val_nxt   = in_data.elem_value[mbe_pkg::CMP_W-1:0];
          ptr_nxt   = '0;
          pend_nxt  = 1'b0;
          state_nxt = S_FIND;
        end
      end

      S_FIND: begin
        if (d_hit || scan_end) begin
          found_nxt  = f_hit;
          idx_nxt    = f_idx;
          cnt_nxt    = '0;
          ptr_nxt    = '0;
          pend_nxt   = 1'b0;
          status_nxt = mbe_pkg::ST_DONE;
          case (op_r)
            mbe_pkg::OP_ADD: begin
              if ((!f_hit && d_full) || s_full) begin
                status_nxt = mbe_pkg::ST_FULL;
                state_nxt  = f_hit ? S_CNT : S_OUT;
              end else begin
                if (!f_hit) begin
                  d_we      = 1'b1;
                  d_waddr   = f_idx;
                  d_wdata   = val_r;
                  dcnt_nxt  = dcnt_r + 1'b1;
                  found_nxt = 1'b1;
                end
                s_we      = 1'b1;
                s_waddr   = scnt_r[mbe_pkg::SIDX_W-1:0];
                s_wdata   = f_idx;
                scnt_nxt  = scnt_r + 1'b1;
                state_nxt = S_CNT;
              end
            end
            mbe_pkg::OP_REMOVE: begin
              if (!f_hit) begin
                status_nxt = mbe_pkg::ST_ABSENT;
                state_nxt  = S_OUT;
              end else begin
                state_nxt = S_POS;
              end
            end
            default: begin
              if (!f_hit) begin
                status_nxt = mbe_pkg::ST_ABSENT;
                state_nxt  = S_OUT;
              end else begin
                state_nxt = S_CNT;
              end
            end
          endcase
        end
      end

      S_CNT: begin
        if (s_hit) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        if (scan_end) begin
          // A remove that took the last occurrence goes on to drop the value.
          if ((op_r == mbe_pkg::OP_REMOVE) && (cnt_r == '0)) begin
            state_nxt = S_DLAST;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end

      S_POS: begin
        if (s_hit) begin
          pos_nxt   = pidx_r[mbe_pkg::SIDX_W-1:0];
          pend_nxt  = 1'b0;
          state_nxt = S_LAST;
        end else if (scan_end) begin
          ptr_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = S_CNT;
        end
      end

      S_LAST: begin
        s_raddr   = s_last;
        state_nxt = S_MOVE;
      end

      S_MOVE: begin
        s_we      = 1'b1;
        s_waddr   = pos_r;
        s_wdata   = s_rdata;
        scnt_nxt  = scnt_m1;
        ptr_nxt   = '0;
        pend_nxt  = 1'b0;
        cnt_nxt   = '0;
        state_nxt = S_CNT;
      end

      S_DLAST: begin
        if (idx_r == d_last) begin
          // The freed entry is the last one: nothing has to move.
          dcnt_nxt  = dcnt_m1;
          found_nxt = 1'b0;
          state_nxt = S_OUT;
        end else begin
          d_raddr   = d_last;
          state_nxt = S_DMOVE;
        end
      end

      S_DMOVE: begin
        d_we      = 1'b1;
        d_waddr   = idx_r;
        d_wdata   = d_rdata;
        ptr_nxt   = '0;
        pend_nxt  = 1'b0;
        state_nxt = S_RENUM;
      end

      S_RENUM: begin
        if (s_hit_last) begin
          s_we    = 1'b1;
          s_waddr = pidx_r[mbe_pkg::SIDX_W-1:0];
          s_wdata = idx_r;
        end
        if (scan_end) begin
          dcnt_nxt  = dcnt_m1;
          found_nxt = 1'b0;
          state_nxt = S_OUT;
        end
      end

      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt       = 1'b1;
          out_nxt.status      = status_r;
          out_nxt.present     = found_r;
          out_nxt.occurrences = found_r ? mbe_pkg::cnt_out(cnt_r) : '0;
          out_nxt.total_count = mbe_pkg::cnt_out(scnt_r);
          out_nxt.is_empty    = (scnt_r == '0);
          state_nxt           = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dcnt_r      <= '0;
      scnt_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dcnt_r      <= dcnt_nxt;
      scnt_r      <= scnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    val_r    <= val_nxt;
    ptr_r    <= ptr_nxt;
    pidx_r   <= pidx_nxt;
    found_r  <= found_nxt;
    idx_r    <= idx_nxt;
    cnt_r    <= cnt_nxt;
    pos_r    <= pos_nxt;
    status_r <= status_nxt;
    out_r    <= out_nxt;
  end

  `ASSERT_ALWAYS(a_slot_cap, scnt_r <= mbe_pkg::BAG_MAX)
  `ASSERT_ALWAYS(a_distinct_cap, dcnt_r <= mbe_pkg::DISTINCT_MAX)
  `ASSERT_IMPLIES(a_distinct_has_slot, state_r == S_IDLE, dcnt_r <= scnt_r)
  `ASSERT_NEXT(a_accept_starts_lookup, in_valid && !in_stall, state_r == S_FIND)

endmodule
